// ===== rtl/trd_pkg.sv =====
// types and constants shared by the text cell run-length decoder
`default_nettype none
package trd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DIM_W      = 16;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned RUN_W      = 7;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLUMNS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS    = 8'd1;

  localparam logic [DIM_W-1:0] COLUMNS_RESET = 16'd80;
  localparam logic [DIM_W-1:0] ROWS_RESET    = 16'd25;

  localparam logic [PHASE_W-1:0] PH_HEADER    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HELD_CHAR = 3'd1;
  localparam logic [PHASE_W-1:0] PH_HELD_ATTR = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RAW_CHAR  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RAW_ATTR  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_RUN_ATTR  = 3'd5;
  localparam logic [PHASE_W-1:0] PH_RUN_CHAR  = 3'd6;

  localparam logic [KIND_W-1:0] KIND_RAW  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ATTR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PAIR = 2'd3;

  // control from the sequencer to the cell index unit
  typedef struct packed {
    logic step;
    logic clear;
  } idx_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/trd_chan_if.sv =====
// channel interfaces: compressed byte items, cell items and configuration writes
`default_nettype none
interface trd_byte_if;
  logic                           valid;
  logic                           ready;
  logic [trd_pkg::BYTE_W-1:0]     stream_byte;
  logic                           final_byte;
  modport source (output valid, output stream_byte, output final_byte, input ready);
  modport sink   (input valid, input stream_byte, input final_byte, output ready);
endinterface

interface trd_cell_if;
  logic                           valid;
  logic                           ready;
  logic [trd_pkg::BYTE_W-1:0]     cell_char;
  logic [trd_pkg::BYTE_W-1:0]     cell_attr;
  logic                           run_end;
  logic                           beyond_image;
  modport source (output valid, output cell_char, output cell_attr, output run_end,
                  output beyond_image, input ready);
  modport sink   (input valid, input cell_char, input cell_attr, input run_end,
                  input beyond_image, output ready);
endinterface

interface trd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [trd_pkg::CFG_IDX_W-1:0]  index;
  logic [trd_pkg::DIM_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/trd_cell_index.sv =====
// image size registers, cell counter and beyond-image compare
`default_nettype none
module trd_cell_index (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [trd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [trd_pkg::DIM_W-1:0]     cfg_data,
  input  wire trd_pkg::idx_ctrl_t            ctrl,
  output logic                               beyond
);

  logic [trd_pkg::DIM_W-1:0]     columns;
  logic [trd_pkg::DIM_W-1:0]     rows;
  logic [trd_pkg::COUNT_W-1:0]   limit;
  logic [trd_pkg::COUNT_W-1:0]   cells;
  logic [trd_pkg::DIM_W-1:0]     columns_next;
  logic [trd_pkg::DIM_W-1:0]     rows_next;

  always_comb begin
    columns_next = columns;
    rows_next    = rows;
    if (cfg_write && cfg_index == trd_pkg::REG_IMAGE_COLUMNS) begin
      columns_next = cfg_data;
    end
    if (cfg_write && cfg_index == trd_pkg::REG_IMAGE_ROWS) begin
      rows_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= trd_pkg::COLUMNS_RESET;
      rows    <= trd_pkg::ROWS_RESET;
      limit   <= trd_pkg::COUNT_W'(trd_pkg::COLUMNS_RESET * trd_pkg::ROWS_RESET);
      cells   <= '0;
    end else begin
      columns <= columns_next;
      rows    <= rows_next;
      limit   <= trd_pkg::COUNT_W'({16'd0, columns_next} * {16'd0, rows_next});
      if (ctrl.clear) begin
        cells <= '0;
      end else if (ctrl.step && cells != '1) begin
        cells <= cells + trd_pkg::COUNT_W'(1);
      end
    end
  end

  assign beyond = (cells >= limit);

endmodule
`default_nettype wire

// ===== rtl/text_cell_rle_decoder_core.sv =====
// text cell run-length decoder top level: header parser and run sequencer
//
//   channel  role    payload
//   stream   sink    stream_byte, final_byte
//   cells    source  cell_char, cell_attr, run_end, beyond_image
//   cfg      sink    index, data (image_columns, image_rows)
//
// a header, character or attribute byte yields at most one cell
// a repeated pair takes one cycle per cell while cells are taken, 1 to 64, from the shared cell emit path
// stream is held off while a repeated pair run is being emitted
// a stalled cell waits in the output register; the block holds until it is taken
// rst is synchronous; cfg is always ready and takes effect on the next cycle
`default_nettype none
module text_cell_rle_decoder_core (
  input  wire logic   clk,
  input  wire logic   rst,
  trd_byte_if.sink    stream,
  trd_cell_if.source  cells,
  trd_cfg_if.sink     cfg
);

  logic [trd_pkg::PHASE_W-1:0] phase, phase_next;
  logic [trd_pkg::KIND_W-1:0]  kind, kind_next;
  logic [trd_pkg::RUN_W-1:0]   remaining, remaining_next;
  logic [trd_pkg::BYTE_W-1:0]  held_char, held_char_next;
  logic [trd_pkg::BYTE_W-1:0]  held_attr, held_attr_next;
  logic                        emitting, emitting_next;
  logic [trd_pkg::RUN_W-1:0]   emit_left, emit_left_next;
  logic                        pend_clear, pend_clear_next;
  logic                        out_valid;
  logic [trd_pkg::BYTE_W-1:0]  out_char;
  logic [trd_pkg::BYTE_W-1:0]  out_attr;
  logic                        out_end;
  logic                        out_beyond;

  logic                        out_free;
  logic                        accept;
  logic                        cell_load;
  logic [trd_pkg::BYTE_W-1:0]  cell_char_n;
  logic [trd_pkg::BYTE_W-1:0]  cell_attr_n;
  logic                        cell_end_n;
  logic [trd_pkg::RUN_W-1:0]   rem_dec;
  logic [trd_pkg::BYTE_W-1:0]  b;
  logic                        beyond;
  trd_pkg::idx_ctrl_t          idx_ctrl;

  assign out_free     = !out_valid || cells.ready;
  assign stream.ready = !emitting && out_free;
  assign accept       = stream.valid && stream.ready;
  assign cfg.ready    = 1'b1;
  assign b            = stream.stream_byte;
  assign rem_dec      = (remaining != '0) ? remaining - trd_pkg::RUN_W'(1) : remaining;

  always_comb begin
    phase_next      = phase;
    kind_next       = kind;
    remaining_next  = remaining;
    held_char_next  = held_char;
    held_attr_next  = held_attr;
    emitting_next   = emitting;
    emit_left_next  = emit_left;
    pend_clear_next = pend_clear;
    cell_load       = 1'b0;
    cell_char_n     = held_char;
    cell_attr_n     = held_attr;
    cell_end_n      = 1'b1;
    idx_ctrl.step   = 1'b0;
    idx_ctrl.clear  = 1'b0;

    if (accept) begin
      case (phase)
        trd_pkg::PH_HELD_CHAR: begin
          held_char_next = b;
          phase_next = (kind == trd_pkg::KIND_PAIR) ? trd_pkg::PH_HELD_ATTR
                                                    : trd_pkg::PH_RUN_ATTR;
        end
        trd_pkg::PH_HELD_ATTR: begin
          held_attr_next = b;
          if (kind == trd_pkg::KIND_PAIR) begin
            if (remaining != '0) begin
              cell_load      = 1'b1;
              cell_char_n    = held_char;
              cell_attr_n    = b;
              cell_end_n     = (remaining == trd_pkg::RUN_W'(1));
              emit_left_next = remaining - trd_pkg::RUN_W'(1);
              emitting_next  = (remaining != trd_pkg::RUN_W'(1));
            end
            remaining_next = '0;
            phase_next     = trd_pkg::PH_HEADER;
          end else begin
            phase_next = trd_pkg::PH_RUN_CHAR;
          end
        end
        trd_pkg::PH_RAW_CHAR: begin
          held_char_next = b;
          phase_next     = trd_pkg::PH_RAW_ATTR;
        end
        trd_pkg::PH_RAW_ATTR: begin
          cell_load      = 1'b1;
          cell_char_n    = held_char;
          cell_attr_n    = b;
          remaining_next = rem_dec;
          phase_next = (rem_dec == '0) ? trd_pkg::PH_HEADER : trd_pkg::PH_RAW_CHAR;
        end
        trd_pkg::PH_RUN_ATTR: begin
          cell_load      = 1'b1;
          cell_char_n    = held_char;
          cell_attr_n    = b;
          remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = trd_pkg::PH_HEADER;
          end
        end
        trd_pkg::PH_RUN_CHAR: begin
          cell_load      = 1'b1;
          cell_char_n    = b;
          cell_attr_n    = held_attr;
          remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = trd_pkg::PH_HEADER;
          end
        end
        default: begin
          kind_next      = b[7:6];
          remaining_next = {1'b0, b[5:0]} + trd_pkg::RUN_W'(1);
          if (b[7:6] == trd_pkg::KIND_RAW) begin
            phase_next = trd_pkg::PH_RAW_CHAR;
          end else if (b[7:6] == trd_pkg::KIND_ATTR) begin
            phase_next = trd_pkg::PH_HELD_ATTR;
          end else begin
            phase_next = trd_pkg::PH_HELD_CHAR;
          end
        end
      endcase
      idx_ctrl.step = cell_load;
      if (stream.final_byte) begin
        phase_next     = trd_pkg::PH_HEADER;
        remaining_next = '0;
        if (emitting_next) begin
          pend_clear_next = 1'b1;
        end else begin
          idx_ctrl.clear = 1'b1;
        end
      end
    end else if (emitting && out_free) begin
      cell_load      = 1'b1;
      cell_char_n    = held_char;
      cell_attr_n    = held_attr;
      cell_end_n     = (emit_left == trd_pkg::RUN_W'(1));
      emit_left_next = emit_left - trd_pkg::RUN_W'(1);
      idx_ctrl.step  = 1'b1;
      if (emit_left == trd_pkg::RUN_W'(1)) begin
        emitting_next   = 1'b0;
        pend_clear_next = 1'b0;
        idx_ctrl.clear  = pend_clear;
      end
    end
  end

  trd_cell_index u_index (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg.valid && cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .ctrl      (idx_ctrl),
    .beyond    (beyond)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= trd_pkg::PH_HEADER;
      kind       <= trd_pkg::KIND_RAW;
      remaining  <= '0;
      held_char  <= '0;
      held_attr  <= '0;
      emitting   <= 1'b0;
      emit_left  <= '0;
      pend_clear <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      kind       <= kind_next;
      remaining  <= remaining_next;
      held_char  <= held_char_next;
      held_attr  <= held_attr_next;
      emitting   <= emitting_next;
      emit_left  <= emit_left_next;
      pend_clear <= pend_clear_next;
      if (cell_load) begin
        out_valid <= 1'b1;
      end else if (cells.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cell_load) begin
      out_char   <= cell_char_n;
      out_attr   <= cell_attr_n;
      out_end    <= cell_end_n;
      out_beyond <= beyond;
    end
  end

  assign cells.valid        = out_valid;
  assign cells.cell_char    = out_char;
  assign cells.cell_attr    = out_attr;
  assign cells.run_end      = out_end;
  assign cells.beyond_image = out_beyond;

  a_emit_in_header: assert property (@(posedge clk) disable iff (rst)
    emitting |-> phase == trd_pkg::PH_HEADER)
    else $error("pair run emitting outside header phase");

  a_emit_left: assert property (@(posedge clk) disable iff (rst)
    emitting |-> emit_left != '0)
    else $error("pair run emitting with no cells left");

  a_pend_clear: assert property (@(posedge clk) disable iff (rst)
    pend_clear |-> emitting)
    else $error("counter clear pending with no run in progress");

  a_final_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && stream.final_byte) |=> (emitting == pend_clear))
    else $error("final item did not schedule the counter clear");

endmodule
`default_nettype wire
